### design/sluf_pkg.sv
// Shared types, constants and a helper function for the signed literal union-find block.
package sluf_pkg;

    localparam int VAR_COUNT  = 1024;
    localparam int VAR_W      = $clog2(VAR_COUNT);
    localparam int LIT_W      = 12;
    localparam int MODE_W     = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef logic [VAR_W-1:0]        var_idx_t;
    typedef logic signed [LIT_W-1:0] lit_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIND  = 2'd0,
        MODE_UNION = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_FIND,
        CMD_UNION,
        CMD_CLEAR,
        CMD_BAD
    } cmd_kind_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t kind;
        var_idx_t  var_a;
        logic      neg_a;
        var_idx_t  var_b;
        logic      neg_b;
    } cmd_t;

    // One link table entry.
    typedef struct packed {
        logic     link;
        var_idx_t par;
        logic     pol;
    } entry_t;

    // Turns a variable index and a polarity into a signed literal.
    function automatic lit_t enc_lit(input var_idx_t idx, input logic neg);
        logic [LIT_W-1:0] mag;
        mag = LIT_W'(idx) + LIT_W'(1);
        return neg ? lit_t'(-mag) : lit_t'(mag);
    endfunction

endpackage

### design/sluf_front.sv
// Front end: accepts input beats, checks literals and classifies each item into a command.
module sluf_front (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [sluf_pkg::MODE_W-1:0] mode,
    input  sluf_pkg::lit_t             lit_a,
    input  sluf_pkg::lit_t             lit_b,
    input  logic                       q_full,
    input  logic                       init_busy,
    output logic                       push,
    output sluf_pkg::cmd_t             cmd
);
    import sluf_pkg::*;

    logic             neg_a;
    logic             neg_b;
    logic [LIT_W-1:0] mag_a;
    logic [LIT_W-1:0] mag_b;
    logic             ok_a;
    logic             ok_b;

    assign s_ready = !q_full && !init_busy;
    assign push    = s_valid && s_ready;

    always_comb begin
        neg_a = lit_a[LIT_W-1];
        neg_b = lit_b[LIT_W-1];
        // The most negative code keeps its magnitude as an unsigned value.
        mag_a = neg_a ? LIT_W'(-lit_a) : LIT_W'(lit_a);
        mag_b = neg_b ? LIT_W'(-lit_b) : LIT_W'(lit_b);
        ok_a  = (mag_a != '0) && (mag_a <= LIT_W'(VAR_COUNT));
        ok_b  = (mag_b != '0) && (mag_b <= LIT_W'(VAR_COUNT));

        cmd.var_a = VAR_W'(mag_a - LIT_W'(1));
        cmd.neg_a = neg_a;
        cmd.var_b = VAR_W'(mag_b - LIT_W'(1));
        cmd.neg_b = neg_b;

        unique case (mode_t'(mode))
            MODE_FIND: begin
                cmd.kind = ok_a ? CMD_FIND : CMD_BAD;
            end
            MODE_UNION: begin
                cmd.kind = (ok_a && ok_b) ? CMD_UNION : CMD_BAD;
            end
            MODE_CLEAR: begin
                cmd.kind = CMD_CLEAR;
            end
            default: begin
                cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

### design/sluf_queue.sv
// Short command queue between the front end and the back end.
module sluf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sluf_pkg::cmd_t push_cmd,
    input  logic           pop,
    output sluf_pkg::cmd_t head_cmd,
    output logic           not_empty,
    output logic           full
);
    import sluf_pkg::*;

    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/sluf_back.sv
// Back end: owns the link table (sweep, walk, compress, link) and drives the result register.
module sluf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  sluf_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    output logic           init_busy,
    output logic           m_valid,
    input  logic           m_ready,
    output sluf_pkg::lit_t root_lit,
    output logic           merged,
    output logic           bad_literal
);
    import sluf_pkg::*;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_EMIT
    } state_t;

    entry_t   link_mem [VAR_COUNT];
    entry_t   rdata_reg;
    var_idx_t rd_addr;
    logic     wr_en;
    var_idx_t wr_addr;
    entry_t   wr_data;

    state_t   state_reg,     state_next;
    var_idx_t sweep_cnt_reg, sweep_cnt_next;
    logic     sweep_cmd_reg, sweep_cmd_next;
    cmd_t     cmd_reg,       cmd_next;
    var_idx_t cur_reg;
    var_idx_t start_reg,     start_next;
    var_idx_t root_reg,      root_next;
    logic     p_reg,         p_next;
    logic     pu_reg,        pu_next;
    logic     side_reg,      side_next;
    var_idx_t r1_reg,        r1_next;
    logic     n1_reg,        n1_next;
    lit_t     res_root_reg,  res_root_next;
    logic     res_merged_reg, res_merged_next;
    logic     res_bad_reg,   res_bad_next;
    logic     m_valid_reg,   m_valid_next;
    lit_t     m_root_reg,    m_root_next;
    logic     m_merged_reg,  m_merged_next;
    logic     m_bad_reg,     m_bad_next;

    logic     out_free;
    logic     root_neg;

    assign init_busy   = (state_reg == ST_SWEEP) && !sweep_cmd_reg;
    assign m_valid     = m_valid_reg;
    assign root_lit    = m_root_reg;
    assign merged      = m_merged_reg;
    assign bad_literal = m_bad_reg;
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_cmd_next  = sweep_cmd_reg;
        cmd_next        = cmd_reg;
        start_next      = start_reg;
        root_next       = root_reg;
        p_next          = p_reg;
        pu_next         = pu_reg;
        side_next       = side_reg;
        r1_next         = r1_reg;
        n1_next         = n1_reg;
        res_root_next   = res_root_reg;
        res_merged_next = res_merged_reg;
        res_bad_next    = res_bad_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_root_next     = m_root_reg;
        m_merged_next   = m_merged_reg;
        m_bad_next      = m_bad_reg;
        rd_addr         = cur_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = '0;
        cmd_pop         = 1'b0;
        root_neg        = (side_reg ? cmd_reg.neg_b : cmd_reg.neg_a) ^ p_reg;

        unique case (state_reg)
            ST_SWEEP: begin
                wr_en          = 1'b1;
                wr_addr        = sweep_cnt_reg;
                wr_data        = '0;
                sweep_cnt_next = sweep_cnt_reg + VAR_W'(1);
                if (sweep_cnt_reg == VAR_W'(VAR_COUNT - 1)) begin
                    sweep_cmd_next = 1'b0;
                    if (sweep_cmd_reg) begin
                        res_root_next   = '0;
                        res_merged_next = 1'b0;
                        res_bad_next    = 1'b0;
                        state_next      = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop         = 1'b1;
                    cmd_next        = cmd;
                    p_next          = 1'b0;
                    side_next       = 1'b0;
                    start_next      = cmd.var_a;
                    rd_addr         = cmd.var_a;
                    res_root_next   = '0;
                    res_merged_next = 1'b0;
                    res_bad_next    = 1'b0;
                    unique case (cmd.kind)
                        CMD_FIND, CMD_UNION: begin
                            state_next = ST_WALK;
                        end
                        CMD_CLEAR: begin
                            sweep_cnt_next = '0;
                            sweep_cmd_next = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        CMD_BAD: begin
                            res_bad_next = 1'b1;
                            state_next   = ST_EMIT;
                        end
                        default: begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // rdata_reg holds the entry of cur_reg.
                if (rdata_reg.link) begin
                    p_next  = p_reg ^ rdata_reg.pol;
                    rd_addr = rdata_reg.par;
                end else begin
                    root_next  = cur_reg;
                    pu_next    = 1'b0;
                    rd_addr    = start_reg;
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                if (rdata_reg.link && (cur_reg != root_reg)) begin
                    // Point this node straight at the root.
                    wr_en   = 1'b1;
                    wr_addr = cur_reg;
                    wr_data = '{link: 1'b1, par: root_reg, pol: p_reg ^ pu_reg};
                    pu_next = pu_reg ^ rdata_reg.pol;
                    rd_addr = rdata_reg.par;
                end else if (!side_reg && (cmd_reg.kind == CMD_UNION)) begin
                    r1_next    = root_reg;
                    n1_next    = root_neg;
                    side_next  = 1'b1;
                    p_next     = 1'b0;
                    start_next = cmd_reg.var_b;
                    rd_addr    = cmd_reg.var_b;
                    state_next = ST_WALK;
                end else if (!side_reg) begin
                    res_root_next = enc_lit(root_reg, root_neg);
                    state_next    = ST_EMIT;
                end else if (r1_reg == root_reg) begin
                    // Same root variable on both sides: nothing is linked.
                    res_root_next = enc_lit(r1_reg, n1_reg);
                    state_next    = ST_EMIT;
                end else begin
                    wr_en           = 1'b1;
                    wr_addr         = r1_reg;
                    wr_data         = '{link: 1'b1, par: root_reg, pol: n1_reg ^ root_neg};
                    res_root_next   = enc_lit(root_reg, root_neg);
                    res_merged_next = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_root_next   = res_root_reg;
                    m_merged_next = res_merged_reg;
                    m_bad_next    = res_bad_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Link table: at most one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= rd_addr;
        cmd_reg        <= cmd_next;
        start_reg      <= start_next;
        root_reg       <= root_next;
        p_reg          <= p_next;
        pu_reg         <= pu_next;
        side_reg       <= side_next;
        r1_reg         <= r1_next;
        n1_reg         <= n1_next;
        res_root_reg   <= res_root_next;
        res_merged_reg <= res_merged_next;
        res_bad_reg    <= res_bad_next;
        m_root_reg     <= m_root_next;
        m_merged_reg   <= m_merged_next;
        m_bad_reg      <= m_bad_next;
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            sweep_cmd_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            sweep_cmd_reg <= sweep_cmd_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // No entry may ever be linked to itself.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && wr_data.link) |-> (wr_data.par != wr_addr))
        else $error("link table entry written as its own parent");

    // During compression the next read never targets the entry being rewritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP && wr_en && rdata_reg.link && cur_reg != root_reg)
            |-> (rd_addr != wr_addr))
        else $error("compression read collides with its own write");

    // Commands are only taken when idle and present.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (state_reg == ST_IDLE && cmd_valid))
        else $error("command popped outside the idle state");

    // A rejected literal never reports a root or a merge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_bad_reg) |-> (m_root_reg == '0 && !m_merged_reg))
        else $error("bad literal result carries a root or a merge");

endmodule

### design/signed_literal_union_find.sv
// Top level of the signed literal union-find block: front end, command queue and back end.
//
// Channel   Direction  Beat contents
// s_        in         tuser: mode[1:0]; tdata: lit_a[11:0], lit_b[23:12]
// m_        out        tdata: root_lit[11:0], zeros[15:12]; tuser: merged[0], bad_literal[1]
//
// For a find, the back end reads the link table once per chain step up to the root, then
// walks the chain a second time rewriting each node to point at the root. A union walks
// and compresses the chain of lit_a and then that of lit_b, with any link written in the
// last compression cycle; chains stay short thanks to the compression.
// After reset, and for every clear item, the back end sweeps the whole 1024-entry link table,
// one entry a cycle; during the sweep that follows reset s_tready stays low.
// The two-entry command queue lets the front end keep taking beats while the back end works,
// and the result register holds a finished beat while m_tready is low.
module signed_literal_union_find (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sluf_pkg::S_TDATA_W-1:0]   s_tdata,   // lit_a, lit_b
    input  logic [sluf_pkg::MODE_W-1:0]      s_tuser,   // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sluf_pkg::M_TDATA_W-1:0]   m_tdata,   // root_lit, zero padding
    output logic [sluf_pkg::M_TUSER_W-1:0]   m_tuser    // merged, bad_literal
);
    import sluf_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_not_empty;
    logic init_busy;
    lit_t root_lit;
    logic merged;
    logic bad_literal;

    // The front end only looks at the incoming beat, the queue's fill state and init_busy.
    sluf_front u_front (
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .mode      (s_tuser),
        .lit_a     (lit_t'(s_tdata[LIT_W-1:0])),
        .lit_b     (lit_t'(s_tdata[2*LIT_W-1:LIT_W])),
        .q_full    (q_full),
        .init_busy (init_busy),
        .push      (push),
        .cmd       (front_cmd)
    );

    sluf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // The back end owns the link table and the output register.
    sluf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (head_cmd),
        .cmd_valid   (q_not_empty),
        .cmd_pop     (pop),
        .init_busy   (init_busy),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .root_lit    (root_lit),
        .merged      (merged),
        .bad_literal (bad_literal)
    );

    assign m_tdata = {{(M_TDATA_W - LIT_W){1'b0}}, root_lit};
    assign m_tuser = {bad_literal, merged};

endmodule

### dv/signed_literal_union_find_test.sv
// Self-checking stream testbench for the signed literal union-find block.
`timescale 1ns / 100ps

module signed_literal_union_find_test;
    import sluf_pkg::*;

    // The fourth mode code has no meaning; the block answers it with an all-zero beat.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int DIRECTED_ROWS = 25;
    localparam int PHASE_ITEMS   = 250;
    // The long receiver hold-off starts early in the phase with no idling at all.
    localparam int HOLD_AT       = DIRECTED_ROWS + 2 * PHASE_ITEMS + 40;
    localparam int LONG_HOLD     = 400;
    localparam int TAIL_CYCLES   = 200;
    // A worst-case find walks a 1024-long chain twice, a union does two of those, and a
    // clear sweeps the whole table; with stalls on both sides this bound is several times
    // the slowest legal run.
    localparam int CYCLE_LIMIT   = 20_000_000;

    // Fields of one result beat as the checker sees them.
    typedef struct packed {
        lit_t root;
        logic merged;
        logic bad;
    } root_report_t;

    // One row of the directed table: the stimulus, and an expected beat where it is obvious.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        lit_t              lit_a;
        lit_t              lit_b;
        logic              typed;
        lit_t              want_root;
        logic              want_merged;
        logic              want_bad;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [MODE_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Shadow copy of the link table, indexed by variable number 1..VAR_COUNT.
    bit link_on  [1:VAR_COUNT];
    int link_up  [1:VAR_COUNT];
    bit link_neg [1:VAR_COUNT];

    root_report_t pending_roots[$];
    stim_row_t    directed[DIRECTED_ROWS];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int beats_in      = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    signed_literal_union_find u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic void empty_table();
        for (int v = 1; v <= VAR_COUNT; v++) begin
            link_on[v]  = 1'b0;
            link_up[v]  = 0;
            link_neg[v] = 1'b0;
        end
    endfunction

    function automatic bit lit_in_range(input lit_t lit);
        int mag;
        mag = (lit < 0) ? -int'(lit) : int'(lit);
        return (mag >= 1) && (mag <= VAR_COUNT);
    endfunction

    function automatic lit_t signed_root(input int var_num, input bit neg);
        return neg ? lit_t'(-var_num) : lit_t'(var_num);
    endfunction

    // Follows the parent chain of a literal to its root variable and then points every
    // node on the walked path straight at that root, keeping the parity consistent.
    function automatic int trace_root(input lit_t lit, output bit neg);
        int start, v, steps, u, nxt, k;
        bit sign, par, pu, np;
        start = (lit < 0) ? -int'(lit) : int'(lit);
        sign  = (lit < 0);
        v     = start;
        par   = 1'b0;
        steps = 0;
        while (link_on[v] && steps < VAR_COUNT) begin
            par ^= link_neg[v];
            v = link_up[v];
            steps++;
        end
        u  = start;
        pu = 1'b0;
        k  = 0;
        while (link_on[u] && u != v && k < VAR_COUNT) begin
            nxt = link_up[u];
            np  = pu ^ link_neg[u];
            link_up[u]  = v;
            link_neg[u] = par ^ pu;
            u  = nxt;
            pu = np;
            k++;
        end
        neg = sign ^ par;
        return v;
    endfunction

    // Works out the result beat of one accepted input beat and updates the shadow table.
    function automatic root_report_t predict_root(input logic [MODE_W-1:0] mode,
                                                  input lit_t lit_a, input lit_t lit_b);
        root_report_t rep;
        int ra, rb;
        bit na, nb;
        rep = '0;
        case (mode)
            MODE_FIND: begin
                if (!lit_in_range(lit_a)) begin
                    rep.bad = 1'b1;
                end else begin
                    ra = trace_root(lit_a, na);
                    rep.root = signed_root(ra, na);
                end
            end
            MODE_UNION: begin
                // Both literals are checked before either chain is touched.
                if (!lit_in_range(lit_a) || !lit_in_range(lit_b)) begin
                    rep.bad = 1'b1;
                end else begin
                    ra = trace_root(lit_a, na);
                    rb = trace_root(lit_b, nb);
                    if (ra == rb) begin
                        // Already equal or contradictory: nothing is linked.
                        rep.root = signed_root(ra, na);
                    end else begin
                        link_on[ra]  = 1'b1;
                        link_up[ra]  = rb;
                        link_neg[ra] = na ^ nb;
                        rep.root   = signed_root(rb, nb);
                        rep.merged = 1'b1;
                    end
                end
            end
            MODE_CLEAR: empty_table();
            default: ;
        endcase
        return rep;
    endfunction

    // Offers one beat, waits for it to be taken and records what should come back.
    // Called just after aclk rises; all that it drives changes only while aclk falls.
    task automatic send_beat(input logic [MODE_W-1:0] mode, input lit_t lit_a,
                             input lit_t lit_b, input logic typed, input root_report_t want);
        root_report_t rep;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {lit_b, lit_a};
        do @(posedge aclk); while (!s_tready);
        rep = predict_root(mode, lit_a, lit_b);
        pending_roots.insert(pending_roots.size(), typed ? want : rep);
        beats_in++;
    endtask

    // Mostly literals from a small pool of low variables plus the top of the range, so that
    // unions keep meeting existing classes and chains grow before the next clear.
    function automatic lit_t pool_lit();
        int v;
        v = ($urandom_range(3) == 0) ? $urandom_range(VAR_COUNT, VAR_COUNT - 23)
                                     : $urandom_range(24, 1);
        return $urandom_range(1) ? lit_t'(-v) : lit_t'(v);
    endfunction

    initial begin
        stim_row_t    row;
        root_report_t want;
        logic [MODE_W-1:0] mode;
        lit_t lit_a, lit_b;
        int roll;

        empty_table();

        // Columns: mode, lit_a, lit_b, typed, root_lit, merged, bad_literal.
        // Fresh table: every literal is its own root.
        directed[0]  = '{MODE_FIND,   12'sd1,     12'sd0,    1'b1, 12'sd1,     1'b0, 1'b0};
        directed[1]  = '{MODE_FIND,   -12'sd1024, 12'sd0,    1'b1, -12'sd1024, 1'b0, 1'b0};
        // Bad literals: zero, one past the top, and the far ends of the 12-bit field.
        directed[2]  = '{MODE_FIND,   12'sd0,     12'sd5,    1'b1, 12'sd0,     1'b0, 1'b1};
        directed[3]  = '{MODE_FIND,   12'sd1025,  12'sd5,    1'b1, 12'sd0,     1'b0, 1'b1};
        directed[4]  = '{MODE_FIND,   12'sh800,   12'sd5,    1'b1, 12'sd0,     1'b0, 1'b1};
        directed[5]  = '{MODE_FIND,   12'sd2047,  12'sd5,    1'b1, 12'sd0,     1'b0, 1'b1};
        directed[6]  = '{MODE_UNION,  12'sd0,     12'sd5,    1'b1, 12'sd0,     1'b0, 1'b1};
        directed[7]  = '{MODE_UNION,  12'sd5,     -12'sd1025, 1'b1, 12'sd0,    1'b0, 1'b1};
        // First merge links variable 1 under variable 2 with opposite polarity.
        directed[8]  = '{MODE_UNION,  12'sd1,     -12'sd2,   1'b1, -12'sd2,    1'b1, 1'b0};
        directed[9]  = '{MODE_FIND,   12'sd1,     12'sd0,    1'b0, 12'sd0,     1'b0, 1'b0};
        directed[10] = '{MODE_FIND,   -12'sd1,    12'sd0,    1'b0, 12'sd0,     1'b0, 1'b0};
        // Same root variable: first contradictory, then already equal.
        directed[11] = '{MODE_UNION,  12'sd2,     12'sd1,    1'b0, 12'sd0,     1'b0, 1'b0};
        directed[12] = '{MODE_UNION,  -12'sd1,    12'sd2,    1'b0, 12'sd0,     1'b0, 1'b0};
        directed[13] = '{MODE_UNION,  12'sd1024,  12'sd1023, 1'b1, 12'sd1023,  1'b1, 1'b0};
        directed[14] = '{MODE_UNION,  12'sd3,     12'sd1024, 1'b0, 12'sd0,     1'b0, 1'b0};
        // A find ignores lit_b, even when it is not a legal literal.
        directed[15] = '{MODE_FIND,   12'sd1024,  12'sd0,    1'b0, 12'sd0,     1'b0, 1'b0};
        directed[16] = '{MODE_UNUSED, 12'sd7,     -12'sd7,   1'b1, 12'sd0,     1'b0, 1'b0};
        directed[17] = '{MODE_UNION,  -12'sd1023, -12'sd2,   1'b0, 12'sd0,     1'b0, 1'b0};
        directed[18] = '{MODE_FIND,   12'sd3,     12'sd0,    1'b0, 12'sd0,     1'b0, 1'b0};
        directed[19] = '{MODE_FIND,   12'sd1,     12'sh800,  1'b0, 12'sd0,     1'b0, 1'b0};
        directed[20] = '{MODE_CLEAR,  12'sd0,     12'sd0,    1'b1, 12'sd0,     1'b0, 1'b0};
        directed[21] = '{MODE_FIND,   12'sd3,     12'sd0,    1'b1, 12'sd3,     1'b0, 1'b0};
        directed[22] = '{MODE_UNION,  12'sd1024,  -12'sd1024, 1'b0, 12'sd0,    1'b0, 1'b0};
        directed[23] = '{MODE_UNION,  12'sd4,     12'sd2047, 1'b1, 12'sd0,     1'b0, 1'b1};
        directed[24] = '{MODE_UNION,  -12'sd1,    12'sd1,    1'b0, 12'sd0,     1'b0, 1'b0};

        // Reset is held low from time zero; the block then sweeps its table with s_tready low,
        // which the first handshake simply waits out.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 62;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row  = directed[i];
            want = '{row.want_root, row.want_merged, row.want_bad};
            send_beat(row.mode, row.lit_a, row.lit_b, row.typed, want);
        end

        // Three random phases: sender idles more lightly, then the receiver does, then neither.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 29 : 0;
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 3) begin
                    mode  = MODE_CLEAR;
                    lit_a = lit_t'($urandom);
                    lit_b = lit_t'($urandom);
                end else if (roll < 5) begin
                    mode  = MODE_UNUSED;
                    lit_a = lit_t'($urandom);
                    lit_b = lit_t'($urandom);
                end else if (roll < 13) begin
                    // Noise over the whole field: mostly bad literals, every bit toggles.
                    mode  = $urandom_range(1) ? MODE_UNION : MODE_FIND;
                    lit_a = lit_t'($urandom);
                    lit_b = lit_t'($urandom);
                end else if (roll < 58) begin
                    mode  = MODE_UNION;
                    lit_a = pool_lit();
                    lit_b = pool_lit();
                end else begin
                    mode  = MODE_FIND;
                    lit_a = pool_lit();
                    lit_b = lit_t'($urandom);
                end
                send_beat(mode, lit_a, lit_b, 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_roots.size() != 0) @(posedge aclk);
        // Give a stray extra beat time to show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("signed_literal_union_find regression: pass");
        end else begin
            $display("signed_literal_union_find regression: fail");
        end
        $finish;
    end

    // Receiver: random back-pressure per phase, plus one long hold-off so that the command
    // queue and the result register fill up and s_tready drops.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && beats_in >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compares each result beat taken with the oldest outstanding expectation.
    always @(posedge aclk) begin : check_results
        root_report_t want;
        lit_t         got_root;
        if (aresetn && m_tvalid && m_tready) begin
            got_root = lit_t'(m_tdata[LIT_W-1:0]);
            if (pending_roots.size() == 0) begin
                $error("result beat with nothing expected: root_lit %0d", got_root);
                fail_count++;
            end else begin
                want = pending_roots.pop_front();
                if (got_root !== want.root) begin
                    $error("root_lit: expected %0d, got %0d", want.root, got_root);
                    fail_count++;
                end
                if (m_tuser[0] !== want.merged) begin
                    $error("merged: expected %0b, got %0b", want.merged, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] !== want.bad) begin
                    $error("bad_literal: expected %0b, got %0b", want.bad, m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("signed_literal_union_find regression: fail");
            $finish;
        end
    end

endmodule

### signed_literal_union_find.f
design/sluf_pkg.sv
design/sluf_front.sv
design/sluf_queue.sv
design/sluf_back.sv
design/signed_literal_union_find.sv
dv/signed_literal_union_find_test.sv
